FILE: src/rc_frame_receiver_crc16_defines.svh
// Assertion macros for the RC frame receiver.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef RC_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define RC_FRAME_RECEIVER_CRC16_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCFR_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rcfr check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define RCFR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rcfr check failed: next-cycle rule");

`endif

FILE: src/rcfr_pkg.sv
// Shared types and constants for the RC frame receiver.
// No dependencies; imported by the deframer and the top level.
`default_nettype none

package rcfr_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int FRAME_MAX_DEF = 70;
    localparam int NUM_CH_DEF    = 16;

    // Frame layout and protocol bytes.
    localparam logic [7:0] START_BYTE    = 8'h3E;
    localparam logic [7:0] RC_PACKET     = 8'h31;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd7;
    localparam logic [7:0] SHORT_LEN     = 8'd3;
    localparam logic [7:0] POS_LENGTH    = 8'd2;
    localparam logic [7:0] POS_TYPE      = 8'd4;
    localparam int         CH_BASE_WORD  = 3;

    // Configuration register reset values and saturation.
    localparam logic [15:0] JUNK_LIMIT_RST = 16'd1000;
    localparam logic [15:0] MID_VALUE_RST  = 16'd1500;
    localparam logic [15:0] JUNK_SAT       = 16'hFFFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUNK_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_VALUE  = 2'd1;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_POLL = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic {
        ST_HUNT  = 1'b0,
        ST_FRAME = 1'b1
    } t_dfr_state;

    // Per-request flags from the deframer to the result path.
    typedef struct packed {
        logic frame_ended;
        logic crc_good;
        logic frame_ready;
        logic baud_changed;
        logic baud_fast;
    } t_rc_status;

endpackage

`default_nettype wire

FILE: src/rcfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 35,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/rcfr_deframer.sv
// Byte deframer, running CRC, junk counter and baud selection state.
// Depends on rcfr_pkg; drives the frame store write port.
`default_nettype none

module rcfr_deframer
    import rcfr_pkg::*;
#(
    parameter int FRAME_MAX = FRAME_MAX_DEF,
    localparam int BAW = $clog2(FRAME_MAX)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire t_op             i_op,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [15:0]     i_junk_limit,
    output logic                 o_wr_en,
    output logic [BAW-1:0]       o_wr_addr,
    output logic [7:0]           o_wr_data,
    output t_rc_status           o_stat
);

    t_dfr_state  r_state, n_state;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_exp_len, n_exp_len;
    logic [15:0] r_crc, n_crc;
    logic        r_ready, n_ready;
    logic        r_baud_vld, n_baud_vld;
    logic [15:0] r_junk, n_junk;
    logic        r_fast, n_fast;

    // Reflected CRC-16-CCITT (poly 0x8408), one byte per call.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
    endfunction

    function automatic logic [15:0] junk_add(input logic [15:0] j, input logic [7:0] n);
        logic [16:0] s;
        s = {1'b0, j} + {9'b0, n};
        return s[16] ? JUNK_SAT : s[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HUNT;
            r_pos      <= '0;
            r_exp_len  <= '0;
            r_crc      <= '0;
            r_ready    <= 1'b0;
            r_baud_vld <= 1'b0;
            r_junk     <= '0;
            r_fast     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_exp_len  <= n_exp_len;
            r_crc      <= n_crc;
            r_ready    <= n_ready;
            r_baud_vld <= n_baud_vld;
            r_junk     <= n_junk;
            r_fast     <= n_fast;
        end
    end

    always_comb begin
        logic        go;
        logic        abort_now;
        logic [7:0]  pos_cur;
        logic [7:0]  pos_nx;
        logic [7:0]  exp_len;
        logic [15:0] crc_cur;
        logic [15:0] crc_nx;

        n_state    = r_state;
        n_pos      = r_pos;
        n_exp_len  = r_exp_len;
        n_crc      = r_crc;
        n_ready    = r_ready;
        n_baud_vld = r_baud_vld;
        n_junk     = r_junk;
        n_fast     = r_fast;
        o_stat     = '0;
        o_wr_en    = 1'b0;
        go         = 1'b0;
        abort_now  = 1'b0;
        pos_cur    = r_pos;
        exp_len    = r_exp_len;
        crc_cur    = r_crc;
        pos_nx     = r_pos + 8'd1;
        crc_nx     = crc_step(r_crc, i_rx_byte);

        if (i_accept) begin
            case (i_op)
                OP_BYTE: begin
                    if (r_state == ST_HUNT) begin
                        if (i_rx_byte != START_BYTE) begin
                            n_junk = junk_add(r_junk, 8'd1);
                        end else begin
                            go      = 1'b1;
                            n_ready = 1'b0;
                            pos_cur = '0;
                            exp_len = MIN_FRAME_LEN;
                            crc_cur = '0;
                        end
                    end else begin
                        go = 1'b1;
                        if (r_pos == POS_LENGTH) begin
                            exp_len   = i_rx_byte;
                            abort_now = (i_rx_byte > 8'(FRAME_MAX)) ||
                                        (i_rx_byte < SHORT_LEN);
                        end else if (r_pos == POS_TYPE && i_rx_byte != RC_PACKET) begin
                            abort_now = 1'b1;
                        end
                    end

                    if (go) begin
                        o_wr_en   = pos_cur < 8'(FRAME_MAX);
                        pos_nx    = pos_cur + 8'd1;
                        crc_nx    = crc_step(crc_cur, i_rx_byte);
                        n_pos     = pos_nx;
                        n_crc     = crc_nx;
                        n_exp_len = exp_len;
                        n_state   = ST_FRAME;
                        if (abort_now) begin
                            n_state = ST_HUNT;
                        end else if (pos_nx == exp_len) begin
                            o_stat.frame_ended = 1'b1;
                            n_state            = ST_HUNT;
                            if (crc_nx == '0) begin
                                n_baud_vld      = 1'b1;
                                n_ready         = 1'b1;
                                o_stat.crc_good = 1'b1;
                            end else begin
                                n_junk = junk_add(r_junk, exp_len);
                            end
                        end
                    end
                end
                OP_POLL: begin
                    if (r_ready) begin
                        n_ready            = 1'b0;
                        o_stat.frame_ready = 1'b1;
                    end else if (!r_baud_vld && r_junk > i_junk_limit) begin
                        n_junk              = '0;
                        n_fast              = ~r_fast;
                        o_stat.baud_changed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        o_stat.baud_fast = n_fast;
        o_wr_addr        = pos_cur[BAW-1:0];
        o_wr_data        = i_rx_byte;
    end

endmodule

`default_nettype wire

FILE: src/rc_frame_receiver_crc16.sv
// Top level of the RC frame receiver: stream ports, configuration registers,
// frame store and result pipeline. Depends on rcfr_pkg, rcfr_ram, rcfr_deframer.
//
//   Channel   Direction  Ports                         Contents
//   request   in         i_s_tvalid/o_s_tready         tuser op, tdata byte and channel
//   result    out        o_m_tvalid/i_m_tready         tlast frame end, tdata flags, value
//   config    in         i_cfg_valid/o_cfg_ready       register index and write data
//
// For every request, the deframer updates its state and
// the frame store is read at the accepting edge, and the channel word is scaled
// from stage 1 into the output register. One request is taken per cycle while
// the result side takes results. Reset is synchronous and active low; the frame
// store keeps a valid bit per byte, so it reads as zero until written without
// a clearing pass. A stalled result holds both pipeline stages and lowers
// o_s_tready; configuration writes are always taken.
`default_nettype none

`include "rc_frame_receiver_crc16_defines.svh"

module rc_frame_receiver_crc16
    import rcfr_pkg::*;
#(
    parameter int FRAME_MAX    = FRAME_MAX_DEF,
    parameter int NUM_CHANNELS = NUM_CH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request stream.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [15:0]          i_s_tdata,   // [7:0] rx_byte, [12:8] channel, rest zero
    input  wire logic [1:0]           i_s_tuser,   // [1:0] op
    // Result stream.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [23:0]               o_m_tdata,   // [0] crc_good, [1] frame_ready,
                                                   // [2] baud_changed, [3] baud_fast,
                                                   // [19:4] channel_value, rest zero
    output logic                      o_m_tlast,   // frame_ended
    // Configuration writes.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    // The store is split into even and odd byte lanes so that one read
    // returns both bytes of a channel word.
    localparam int BAW   = $clog2(FRAME_MAX);
    localparam int DEPTH = (FRAME_MAX + 1) / 2;
    localparam int WAW   = $clog2(DEPTH);

    logic [15:0] r_junk_limit;
    logic [15:0] r_mid_value;

    logic        s_accept;
    logic        s_advance;
    t_op         s_op;
    logic [7:0]  s_rx_byte;
    logic [4:0]  s_channel;
    logic        s_rd_hit;
    logic [WAW-1:0] s_rd_word;

    logic           wr_en;
    logic [BAW-1:0] wr_addr;
    logic [7:0]     wr_data;
    t_rc_status     dfr_stat;

    logic [DEPTH-1:0] r_vld_even;
    logic [DEPTH-1:0] r_vld_odd;
    logic [7:0]       lo_q;
    logic [7:0]       hi_q;

    // Stage 1: status of the request and the store read in flight.
    logic       r_s1_vld;
    t_rc_status r_s1_stat;
    logic       r_s1_rd;
    logic       r_s1_mid;
    logic       r_s1_lo_ok;
    logic       r_s1_hi_ok;

    // Output register.
    logic        r_out_vld;
    t_rc_status  r_out_stat;
    logic [15:0] r_out_val;
    logic [15:0] n_out_val;

    assign s_op      = t_op'(i_s_tuser);
    assign s_rx_byte = i_s_tdata[7:0];
    assign s_channel = i_s_tdata[12:8];

    // Both stages move together whenever the output register is free or drained.
    assign s_advance  = !r_out_vld || i_m_tready;
    assign o_s_tready = s_advance;
    assign s_accept   = i_s_tvalid && s_advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_junk_limit <= JUNK_LIMIT_RST;
            r_mid_value  <= MID_VALUE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_JUNK_LIMIT: r_junk_limit <= i_cfg_data;
                CFG_MID_VALUE:  r_mid_value  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rcfr_deframer #(
        .FRAME_MAX (FRAME_MAX)
    ) u_deframer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_accept),
        .i_op         (s_op),
        .i_rx_byte    (s_rx_byte),
        .i_junk_limit (r_junk_limit),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_stat       (dfr_stat)
    );

    // Channel word ch sits at bytes 6+2ch and 7+2ch, that is word 3+ch of each lane.
    assign s_rd_hit  = (s_op == OP_READ) && (s_channel < 5'(NUM_CHANNELS));
    assign s_rd_word = s_rd_hit ? (WAW'(s_channel) + WAW'(CH_BASE_WORD)) : '0;

    rcfr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_even (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && !wr_addr[0]),
        .i_wr_addr (wr_addr[BAW-1:1]),
        .i_wr_data (wr_data),
        .i_rd_en   (s_accept && s_rd_hit),
        .i_rd_addr (s_rd_word),
        .o_rd_data (lo_q)
    );

    rcfr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_odd (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && wr_addr[0]),
        .i_wr_addr (wr_addr[BAW-1:1]),
        .i_wr_data (wr_data),
        .i_rd_en   (s_accept && s_rd_hit),
        .i_rd_addr (s_rd_word),
        .o_rd_data (hi_q)
    );

    // A byte never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_even <= '0;
            r_vld_odd  <= '0;
        end else if (wr_en) begin
            if (wr_addr[0]) begin
                r_vld_odd[wr_addr[BAW-1:1]] <= 1'b1;
            end else begin
                r_vld_even[wr_addr[BAW-1:1]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_advance) begin
            r_s1_vld <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_stat  <= dfr_stat;
            r_s1_rd    <= s_rd_hit;
            r_s1_mid   <= (s_op == OP_READ) && !s_rd_hit;
            r_s1_lo_ok <= s_rd_hit && r_vld_even[s_rd_word];
            r_s1_hi_ok <= s_rd_hit && r_vld_odd[s_rd_word];
        end
    end

    // Scale the channel word as (word + 4) / 8; the sum keeps its carry.
    always_comb begin
        logic [15:0] word;
        logic [16:0] sum;
        word = {(r_s1_hi_ok ? hi_q : 8'h00), (r_s1_lo_ok ? lo_q : 8'h00)};
        sum  = {1'b0, word} + 17'd4;
        if (r_s1_rd) begin
            n_out_val = 16'(sum >> 3);
        end else if (r_s1_mid) begin
            n_out_val = r_mid_value;
        end else begin
            n_out_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_advance) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && r_s1_vld) begin
            r_out_stat <= r_s1_stat;
            r_out_val  <= n_out_val;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tlast  = r_out_stat.frame_ended;
    assign o_m_tdata  = {4'b0000, r_out_val, r_out_stat.baud_fast,
                         r_out_stat.baud_changed, r_out_stat.frame_ready,
                         r_out_stat.crc_good};

    // A good CRC is only reported on the byte that ends a frame.
    `RCFR_ASSERT_NOW(a_crc_good_on_end, o_m_tvalid && r_out_stat.crc_good, o_m_tlast)
    // Poll outcomes exclude each other and never appear on a frame end.
    `RCFR_ASSERT_NOW(a_poll_flags_excl, o_m_tvalid, !(r_out_stat.frame_ready && r_out_stat.baud_changed) && !(o_m_tlast && (r_out_stat.frame_ready || r_out_stat.baud_changed)))
    // Every accepted request occupies the first stage on the next cycle.
    `RCFR_ASSERT_NEXT(a_accept_fills_s1, s_accept, r_s1_vld)

endmodule

`default_nettype wire
